FILE: hdl/glbp_pkg.sv
// Package for the grey LBP 3x3 stream: item structs, register indexes and constants.
// No dependencies; every other file in hdl uses it by scoped names.
`timescale 1ns / 1ps

package glbp_pkg;

   localparam int COLOR_W       = 8;
   localparam int GREY_W        = 8;
   localparam int CODE_W        = 8;
   localparam int CENTRE_COL_W  = 6;
   localparam int ROW_W         = 12;
   localparam int FRAME_WIDTH_W = 7;
   localparam int FRAME_HEIGHT_W = 12;
   localparam int CSR_DATA_W    = 12;
   localparam int CSR_INDEX_W   = 1;

   localparam int DEF_MAX_WIDTH = 64;
   localparam int MIN_SIZE      = 3;
   localparam int RESET_SIZE    = 50;
   localparam int TOP_BIT       = 7;

   // Weighted sum 11*r + 16*g + 5*b fits in 13 bits; grey is the sum over 32.
   localparam int SUM_W       = 13;
   localparam int RED_WEIGHT  = 11;
   localparam int GREEN_WEIGHT = 16;
   localparam int BLUE_WEIGHT = 5;
   localparam int GREY_SHIFT  = 5;

   localparam int OUT_DEPTH = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               frame_start;
   } pixel_type;

   typedef struct packed {
      logic [CODE_W-1:0]       pattern_code;
      logic [CENTRE_COL_W-1:0] centre_col;
      logic [ROW_W-1:0]        centre_row;
      logic                    frame_last;
   } result_type;

   typedef struct packed {
      logic                    hit;
      logic [CENTRE_COL_W-1:0] centre_col;
      logic [ROW_W-1:0]        centre_row;
      logic                    frame_last;
   } pos_type;

endpackage

FILE: hdl/glbp_line_mem.sv
// Line buffer memory: one write port and one read port with registered read data.
// Depends on glbp_pkg for the grey width.
`timescale 1ns / 1ps

module glbp_line_mem #(
   parameter int DEPTH = glbp_pkg::DEF_MAX_WIDTH,
   parameter int AW    = $clog2(glbp_pkg::DEF_MAX_WIDTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [glbp_pkg::GREY_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [glbp_pkg::GREY_W-1:0] rd_data
);

   logic [glbp_pkg::GREY_W-1:0] line_ff [DEPTH];
   logic [glbp_pkg::GREY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/glbp_window.sv
// Two-column history of the 3x3 window and the comparison logic for the LBP code.
// Depends on glbp_pkg for widths.
`timescale 1ns / 1ps

module glbp_window (
   input  logic                        clock,
   input  logic                        step,
   input  logic [glbp_pkg::GREY_W-1:0] top,
   input  logic [glbp_pkg::GREY_W-1:0] mid,
   input  logic [glbp_pkg::GREY_W-1:0] grey,
   output logic [glbp_pkg::CODE_W-1:0] code
);

   logic [glbp_pkg::GREY_W-1:0] win_ff [6];
   logic [glbp_pkg::GREY_W-1:0] centre;

   always_ff @(posedge clock) begin
      if (step) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= grey;
      end
   end

   assign centre = win_ff[4];

   always_comb begin
      code[glbp_pkg::TOP_BIT]     = (win_ff[0] >= centre);
      code[glbp_pkg::TOP_BIT - 1] = (win_ff[1] >= centre);
      code[glbp_pkg::TOP_BIT - 2] = (win_ff[2] >= centre);
      code[glbp_pkg::TOP_BIT - 3] = (win_ff[5] >= centre);
      code[glbp_pkg::TOP_BIT - 4] = (grey >= centre);
      code[glbp_pkg::TOP_BIT - 5] = (mid >= centre);
      code[glbp_pkg::TOP_BIT - 6] = (top >= centre);
      code[glbp_pkg::TOP_BIT - 7] = (win_ff[3] >= centre);
   end

endmodule

FILE: hdl/glbp_out_queue.sv
// Small result queue that decouples the pixel pipeline from the result channel.
// Depends on glbp_pkg for the result struct and the queue depth.
`timescale 1ns / 1ps

module glbp_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  glbp_pkg::result_type push_data,
   input  logic                 pending,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output glbp_pkg::result_type rsp_data
);

   localparam int DEPTH = glbp_pkg::OUT_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);

   glbp_pkg::result_type entry_ff [DEPTH];
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [NW-1:0] count_ff, count_in;
   logic          pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[head_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign full      = (count_ff == NW'(DEPTH)) || (pending && (count_ff == NW'(DEPTH - 1)));

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + PW'(1);
      end
      if (push) begin
         tail_in = (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + PW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + NW'(1);
         2'b01:   count_in = count_ff - NW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: hdl/grey_lbp_3x3_stream.sv
// Top level of the streaming grey conversion and 3x3 local binary pattern block.
// Depends on glbp_pkg, glbp_line_mem, glbp_window and glbp_out_queue.
`timescale 1ns / 1ps

// The block takes one RGB pixel per clock in raster order and converts it to grey as
// (11*r + 16*g + 5*b) / 32. Two line buffers of MAX_WIDTH entries, each a memory with
// registered read data, hold the two rows above, and a two-column register window
// completes the 3x3 neighborhood. Each interior pixel gives one code; border pixels give
// none. Throughput is one item per clock while req_stall is low: the line buffers are
// read on accept and the code is formed in the following cycle, at whose end it is
// pushed into the output queue, which offers it from the next cycle. A three-entry
// output queue absorbs stalls on the result channel; req_stall rises when that queue
// is full, or when it holds two entries while an item is still forming its code. The
// line buffers are not cleared after reset, so an image must start with frame_start,
// and the user writes frame_width and frame_height only between images (not enforced).

module grey_lbp_3x3_stream #(
   parameter int MAX_WIDTH = glbp_pkg::DEF_MAX_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  glbp_pkg::pixel_type                 req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output glbp_pkg::result_type                rsp_data,
   input  logic                                csr_write,
   input  logic [glbp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [glbp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int LW  = (CW + 1 > glbp_pkg::FRAME_WIDTH_W) ? CW + 1 : glbp_pkg::FRAME_WIDTH_W;
   localparam int RW  = glbp_pkg::ROW_W;
   localparam int OCW = glbp_pkg::CENTRE_COL_W;
   localparam int FWW = glbp_pkg::FRAME_WIDTH_W;
   localparam int FHW = glbp_pkg::FRAME_HEIGHT_W;
   localparam int SW  = glbp_pkg::SUM_W;
   localparam int GW  = glbp_pkg::GREY_W;

   logic [FWW-1:0] frame_width_ff;
   logic [FHW-1:0] frame_height_ff;
   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;

   logic           accept;
   logic [LW-1:0]  width_eff;
   logic [LW-1:0]  width_ext;
   logic [FHW-1:0] height_eff;
   logic [CW-1:0]  col_cur;
   logic [RW-1:0]  row_cur;
   logic [LW-1:0]  col_ext;
   logic [LW-1:0]  col_next;
   logic [RW:0]    row_next;
   logic [SW-1:0]  grey_sum;
   logic [GW-1:0]  grey_cur;
   glbp_pkg::pos_type pos_cur;

   logic              stage_valid_ff;
   glbp_pkg::pos_type pos_ff;
   logic [GW-1:0]     grey_ff;
   logic [CW-1:0]     idx_ff;
   logic              bypass_ff;
   logic [GW-1:0]     fwd_ff;

   logic [GW-1:0]              upper_rd;
   logic [GW-1:0]              middle_rd;
   logic [GW-1:0]              top_eff;
   logic [glbp_pkg::CODE_W-1:0] code;
   glbp_pkg::result_type       result;
   logic                       queue_full;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FWW'(glbp_pkg::RESET_SIZE);
         frame_height_ff <= FHW'(glbp_pkg::RESET_SIZE);
      end else if (csr_write) begin
         case (csr_index)
            glbp_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FWW-1:0];
            glbp_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[FHW-1:0];
            default: ;
         endcase
      end
   end

   // Effective frame size and the position of the incoming pixel.
   always_comb begin
      width_ext = LW'(frame_width_ff);
      if (width_ext < LW'(glbp_pkg::MIN_SIZE)) begin
         width_eff = LW'(glbp_pkg::MIN_SIZE);
      end else if (width_ext > LW'(MAX_WIDTH)) begin
         width_eff = LW'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      height_eff = (frame_height_ff < FHW'(glbp_pkg::MIN_SIZE)) ?
                   FHW'(glbp_pkg::MIN_SIZE) : frame_height_ff;

      col_cur  = req_data.frame_start ? '0 : col_ff;
      row_cur  = req_data.frame_start ? '0 : row_ff;
      col_ext  = LW'(col_cur);
      col_next = col_ext + LW'(1);
      row_next = {1'b0, row_cur} + (RW + 1)'(1);

      if (col_next >= width_eff) begin
         col_in = '0;
         row_in = (row_next >= {1'b0, height_eff}) ? '0 : row_next[RW-1:0];
      end else begin
         col_in = col_next[CW-1:0];
         row_in = row_cur;
      end

      pos_cur.hit        = (col_cur >= CW'(2)) && (row_cur >= RW'(2));
      pos_cur.centre_col = OCW'(col_ext - LW'(1));
      pos_cur.centre_row = row_cur - RW'(1);
      pos_cur.frame_last = (col_ext == width_eff - LW'(1)) &&
                           (row_cur == height_eff - FHW'(1));

      grey_sum = SW'(glbp_pkg::RED_WEIGHT) * SW'(req_data.red) +
                 SW'(glbp_pkg::GREEN_WEIGHT) * SW'(req_data.green) +
                 SW'(glbp_pkg::BLUE_WEIGHT) * SW'(req_data.blue);
      grey_cur = grey_sum[SW-1:glbp_pkg::GREY_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // The upper line is written in the cycle after the read, so a pixel that reuses the
   // previous item's column takes that item's middle value directly.
   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff    <= pos_cur;
         grey_ff   <= grey_cur;
         idx_ff    <= col_cur;
         bypass_ff <= stage_valid_ff && (idx_ff == col_cur);
         fwd_ff    <= middle_rd;
      end
   end

   assign top_eff = bypass_ff ? fwd_ff : upper_rd;

   glbp_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_upper_line (
      .clock   (clock),
      .wr_en   (stage_valid_ff),
      .wr_addr (idx_ff),
      .wr_data (middle_rd),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (upper_rd)
   );

   glbp_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_middle_line (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_cur),
      .wr_data (grey_cur),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (middle_rd)
   );

   glbp_window u_window (
      .clock (clock),
      .step  (stage_valid_ff),
      .top   (top_eff),
      .mid   (middle_rd),
      .grey  (grey_ff),
      .code  (code)
   );

   always_comb begin
      result.pattern_code = code;
      result.centre_col   = pos_ff.centre_col;
      result.centre_row   = pos_ff.centre_row;
      result.frame_last   = pos_ff.frame_last;
   end

   glbp_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (stage_valid_ff && pos_ff.hit),
      .push_data (result),
      .pending   (stage_valid_ff),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
